// ===== hdl/robot_nav_mode_controller_core_defines.svh =====
// Assertion macros for the navigation mode controller.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ROBOT_NAV_MODE_CONTROLLER_CORE_DEFINES_SVH
`define ROBOT_NAV_MODE_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RNMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define RNMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RNMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RNMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/rnmc_pkg.sv =====
// Shared types, codes and constants of the navigation mode controller.
// No dependencies; rnmc_cfg_regs, rnmc_nav_fsm and the top level refer to it by scoped names.
package rnmc_pkg;

    // Default sizing.
    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;
    localparam int RETRY_LIMIT_DEF  = 30;

    localparam int CODE_W    = 8;
    localparam int BAND_W    = 10;
    localparam int COORD_W   = 12;
    localparam int RETRY_W   = 6;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 10;

    localparam logic [RETRY_W-1:0] RETRY_MAX = 6'd63;

    // Event kinds.
    localparam logic [2:0] ACT_BYTE   = 3'd0;
    localparam logic [2:0] ACT_TICK   = 3'd1;
    localparam logic [2:0] ACT_VISION = 3'd2;
    localparam logic [2:0] ACT_RUN    = 3'd3;
    localparam logic [2:0] ACT_STOP   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FORWARD       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEFT          = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RIGHT         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEFT_FORWARD  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RIGHT_FORWARD = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_STOP          = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_X             = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_Y             = 4'd7;

    // Register reset values.
    localparam logic [CODE_W-1:0] RST_CODE_FORWARD       = 8'h02;
    localparam logic [CODE_W-1:0] RST_CODE_LEFT          = 8'h04;
    localparam logic [CODE_W-1:0] RST_CODE_RIGHT         = 8'h06;
    localparam logic [CODE_W-1:0] RST_CODE_LEFT_FORWARD  = 8'h01;
    localparam logic [CODE_W-1:0] RST_CODE_RIGHT_FORWARD = 8'h03;
    localparam logic [CODE_W-1:0] RST_CODE_STOP          = 8'h05;
    localparam logic [BAND_W-1:0] RST_BAND_X             = 10'd100;
    localparam logic [BAND_W-1:0] RST_BAND_Y             = 10'd200;

    // Serial frame bytes.
    localparam logic [7:0] FRAME_HEADER      = 8'hFA;
    localparam logic [7:0] BYTE_AVOID_DONE   = 8'h08;
    localparam logic [7:0] BYTE_DRIFT_LEFT   = 8'h07;
    localparam logic [7:0] BYTE_DRIFT_RIGHT  = 8'h09;

    // Deviation direction.
    localparam logic [1:0] DRIFT_NONE  = 2'd0;
    localparam logic [1:0] DRIFT_LEFT  = 2'd1;
    localparam logic [1:0] DRIFT_RIGHT = 2'd2;

    // Frame parser positions.
    localparam logic [1:0] FPOS_HEADER = 2'd0;
    localparam logic [1:0] FPOS_FIRST  = 2'd1;
    localparam logic [1:0] FPOS_SECOND = 2'd2;

    typedef enum logic [1:0] {
        MODE_STATIC  = 2'd0,
        MODE_AVOID   = 2'd1,
        MODE_CORRECT = 2'd2,
        MODE_DETECT  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [2:0]                action;
        logic [7:0]                rx_byte;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic                      target_locked;
    } nav_event_t;

    typedef struct packed {
        logic [CODE_W-1:0] drive_code;
        logic [1:0]        mode;
        logic              reached;
    } nav_result_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_forward;
        logic [CODE_W-1:0] code_left;
        logic [CODE_W-1:0] code_right;
        logic [CODE_W-1:0] code_left_forward;
        logic [CODE_W-1:0] code_right_forward;
        logic [CODE_W-1:0] code_stop;
        logic [BAND_W-1:0] band_x;
        logic [BAND_W-1:0] band_y;
    } cfg_t;

endpackage

// ===== hdl/rnmc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
// The payload type is given at instantiation; no other dependencies.
interface rnmc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rnmc_cfg_regs.sv =====
// Configuration registers: command codes and dead bands.
// Depends on rnmc_pkg.
module rnmc_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rnmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rnmc_pkg::CFG_DAT_W-1:0]       cfg_data,
    output rnmc_pkg::cfg_t                       cfg
);
    rnmc_pkg::cfg_t              cfg_reg;
    rnmc_pkg::cfg_t              cfg_next;
    logic [rnmc_pkg::CODE_W-1:0] code_val;
    logic                        code_ok;

    assign code_val = cfg_data[rnmc_pkg::CODE_W-1:0];
    // A zero command code is refused and the register keeps its value.
    assign code_ok  = (code_val != '0);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rnmc_pkg::CFG_CODE_FORWARD:
                    if (code_ok) cfg_next.code_forward = code_val;
                rnmc_pkg::CFG_CODE_LEFT:
                    if (code_ok) cfg_next.code_left = code_val;
                rnmc_pkg::CFG_CODE_RIGHT:
                    if (code_ok) cfg_next.code_right = code_val;
                rnmc_pkg::CFG_CODE_LEFT_FORWARD:
                    if (code_ok) cfg_next.code_left_forward = code_val;
                rnmc_pkg::CFG_CODE_RIGHT_FORWARD:
                    if (code_ok) cfg_next.code_right_forward = code_val;
                rnmc_pkg::CFG_CODE_STOP:
                    if (code_ok) cfg_next.code_stop = code_val;
                rnmc_pkg::CFG_BAND_X:
                    cfg_next.band_x = cfg_data[rnmc_pkg::BAND_W-1:0];
                rnmc_pkg::CFG_BAND_Y:
                    cfg_next.band_y = cfg_data[rnmc_pkg::BAND_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_forward       <= rnmc_pkg::RST_CODE_FORWARD;
            cfg_reg.code_left          <= rnmc_pkg::RST_CODE_LEFT;
            cfg_reg.code_right         <= rnmc_pkg::RST_CODE_RIGHT;
            cfg_reg.code_left_forward  <= rnmc_pkg::RST_CODE_LEFT_FORWARD;
            cfg_reg.code_right_forward <= rnmc_pkg::RST_CODE_RIGHT_FORWARD;
            cfg_reg.code_stop          <= rnmc_pkg::RST_CODE_STOP;
            cfg_reg.band_x             <= rnmc_pkg::RST_BAND_X;
            cfg_reg.band_y             <= rnmc_pkg::RST_BAND_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== hdl/rnmc_nav_fsm.sv =====
// Navigation state: frame parser, mode machine, retry counter and steering.
// Depends on rnmc_pkg; updates once per transaction presented on fire.
module rnmc_nav_fsm #(
    parameter int IMAGE_WIDTH  = rnmc_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = rnmc_pkg::IMAGE_HEIGHT_DEF,
    parameter int RETRY_LIMIT  = rnmc_pkg::RETRY_LIMIT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  rnmc_pkg::nav_event_t  item,
    input  rnmc_pkg::cfg_t        cfg,
    output rnmc_pkg::nav_result_t result
);
    localparam int CMP_W = rnmc_pkg::COORD_W + 1;
    localparam logic signed [CMP_W-1:0] MID_X = CMP_W'(IMAGE_WIDTH / 2);
    localparam logic signed [CMP_W-1:0] MID_Y = CMP_W'(IMAGE_HEIGHT / 2);
    localparam logic [rnmc_pkg::RETRY_W-1:0] RETRY_LIM = rnmc_pkg::RETRY_W'(RETRY_LIMIT);

    rnmc_pkg::mode_t                   mode_reg, mode_next;
    logic [rnmc_pkg::CODE_W-1:0]       code_reg, code_next;
    logic                              running_reg, running_next;
    logic                              avoid_done_reg, avoid_done_next;
    logic                              seen_reg, seen_next;
    logic                              arrived_reg, arrived_next;
    logic [1:0]                        drift_reg, drift_next;
    logic [rnmc_pkg::RETRY_W-1:0]      retry_reg, retry_next;
    logic [1:0]                        fpos_reg, fpos_next;
    logic [7:0]                        first_reg, first_next;
    logic signed [rnmc_pkg::COORD_W-1:0] cx_reg, cx_next;
    logic signed [rnmc_pkg::COORD_W-1:0] cy_reg, cy_next;

    logic                              lost;
    logic                              can_sidestep;
    logic [rnmc_pkg::CODE_W-1:0]       sidestep_code;
    logic signed [CMP_W-1:0]           cx_ext, cy_ext, band_x_ext, band_y_ext;
    logic signed [CMP_W-1:0]           lo_x, hi_x, hi_y;
    logic                              below_band;
    logic [rnmc_pkg::CODE_W-1:0]       steer_code;

    // Only a centre coordinate of minus one, in x or in y, means that no target is in view.
    assign lost          = (&cx_reg) || (&cy_reg);
    assign can_sidestep  = (drift_reg == rnmc_pkg::DRIFT_LEFT)
                        || (drift_reg == rnmc_pkg::DRIFT_RIGHT);
    // Drifted left means step right, and the other way round.
    assign sidestep_code = (drift_reg == rnmc_pkg::DRIFT_LEFT) ? cfg.code_right
                                                               : cfg.code_left;

    assign cx_ext     = {cx_reg[rnmc_pkg::COORD_W-1], cx_reg};
    assign cy_ext     = {cy_reg[rnmc_pkg::COORD_W-1], cy_reg};
    assign band_x_ext = {{(CMP_W-rnmc_pkg::BAND_W){1'b0}}, cfg.band_x};
    assign band_y_ext = {{(CMP_W-rnmc_pkg::BAND_W){1'b0}}, cfg.band_y};
    assign lo_x       = MID_X - band_x_ext;
    assign hi_x       = MID_X + band_x_ext;
    assign hi_y       = MID_Y + band_y_ext;
    assign below_band = (cy_ext > hi_y);

    always_comb
    begin
        if (cx_ext < lo_x)
            steer_code = cfg.code_left_forward;
        else if (cx_ext > hi_x)
            steer_code = cfg.code_right_forward;
        else
            steer_code = cfg.code_forward;
    end

    // Next mode.
    always_comb
    begin
        mode_next = mode_reg;
        case (item.action)
            rnmc_pkg::ACT_TICK:
            begin
                case (mode_reg)
                    rnmc_pkg::MODE_STATIC:
                        if (running_reg) mode_next = rnmc_pkg::MODE_AVOID;
                    rnmc_pkg::MODE_AVOID:
                        if (avoid_done_reg && can_sidestep)
                            mode_next = rnmc_pkg::MODE_CORRECT;
                    rnmc_pkg::MODE_CORRECT:
                        if (seen_reg) mode_next = rnmc_pkg::MODE_DETECT;
                    rnmc_pkg::MODE_DETECT:
                        if (lost)
                            mode_next = can_sidestep ? rnmc_pkg::MODE_CORRECT
                                                     : rnmc_pkg::MODE_AVOID;
                        else if (arrived_reg)
                            mode_next = rnmc_pkg::MODE_STATIC;
                    default:
                        mode_next = mode_reg;
                endcase
            end
            rnmc_pkg::ACT_STOP:
                mode_next = rnmc_pkg::MODE_STATIC;
            default:
                mode_next = mode_reg;
        endcase
    end

    // Next data state.
    always_comb
    begin
        code_next       = code_reg;
        running_next    = running_reg;
        avoid_done_next = avoid_done_reg;
        seen_next       = seen_reg;
        arrived_next    = arrived_reg;
        drift_next      = drift_reg;
        retry_next      = retry_reg;
        fpos_next       = fpos_reg;
        first_next      = first_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        case (item.action)
            rnmc_pkg::ACT_BYTE:
            begin
                case (fpos_reg)
                    rnmc_pkg::FPOS_HEADER:
                        if (item.rx_byte == rnmc_pkg::FRAME_HEADER)
                            fpos_next = rnmc_pkg::FPOS_FIRST;
                    rnmc_pkg::FPOS_FIRST:
                    begin
                        first_next = item.rx_byte;
                        fpos_next  = rnmc_pkg::FPOS_SECOND;
                    end
                    rnmc_pkg::FPOS_SECOND:
                    begin
                        avoid_done_next = (first_reg == rnmc_pkg::BYTE_AVOID_DONE);
                        if (item.rx_byte == rnmc_pkg::BYTE_DRIFT_LEFT)
                            drift_next = rnmc_pkg::DRIFT_LEFT;
                        else if (item.rx_byte == rnmc_pkg::BYTE_DRIFT_RIGHT)
                            drift_next = rnmc_pkg::DRIFT_RIGHT;
                        else
                            drift_next = rnmc_pkg::DRIFT_NONE;
                        fpos_next = rnmc_pkg::FPOS_HEADER;
                    end
                    default:
                        fpos_next = rnmc_pkg::FPOS_HEADER;
                endcase
            end
            rnmc_pkg::ACT_TICK:
            begin
                case (mode_reg)
                    rnmc_pkg::MODE_AVOID:
                        if (avoid_done_reg && can_sidestep)
                            code_next = sidestep_code;
                    rnmc_pkg::MODE_CORRECT:
                    begin
                        // Seeing the target sets the count to one instead of bumping it, so a
                        // reversal only happens while the target is still missing.
                        if (seen_reg)
                            retry_next = rnmc_pkg::RETRY_W'(1);
                        else
                        begin
                            if (retry_reg == RETRY_LIM)
                                code_next = (code_reg == cfg.code_right) ? cfg.code_left
                                                                         : cfg.code_right;
                            if (retry_reg != rnmc_pkg::RETRY_MAX)
                                retry_next = retry_reg + rnmc_pkg::RETRY_W'(1);
                        end
                    end
                    rnmc_pkg::MODE_DETECT:
                    begin
                        if (lost)
                        begin
                            seen_next  = 1'b0;
                            retry_next = '0;
                            if (can_sidestep)
                                code_next = sidestep_code;
                        end
                        else if (arrived_reg)
                        begin
                            code_next       = cfg.code_stop;
                            running_next    = 1'b0;
                            avoid_done_next = 1'b0;
                            seen_next       = 1'b0;
                            arrived_next    = 1'b0;
                            drift_next      = rnmc_pkg::DRIFT_NONE;
                        end
                        else if (below_band)
                            arrived_next = 1'b1;
                        else
                            code_next = steer_code;
                    end
                    default:
                        code_next = code_reg;
                endcase
            end
            rnmc_pkg::ACT_VISION:
            begin
                cx_next   = item.target_x;
                cy_next   = item.target_y;
                seen_next = item.target_locked;
            end
            rnmc_pkg::ACT_RUN:
            begin
                code_next    = cfg.code_forward;
                running_next = 1'b1;
            end
            rnmc_pkg::ACT_STOP:
            begin
                code_next       = cfg.code_stop;
                running_next    = 1'b0;
                avoid_done_next = 1'b0;
                seen_next       = 1'b0;
                arrived_next    = 1'b0;
                drift_next      = rnmc_pkg::DRIFT_NONE;
            end
            default:
                code_next = code_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= rnmc_pkg::MODE_STATIC;
            code_reg       <= rnmc_pkg::RST_CODE_STOP;
            running_reg    <= 1'b0;
            avoid_done_reg <= 1'b0;
            seen_reg       <= 1'b0;
            arrived_reg    <= 1'b0;
            drift_reg      <= rnmc_pkg::DRIFT_NONE;
            retry_reg      <= '0;
            fpos_reg       <= rnmc_pkg::FPOS_HEADER;
            first_reg      <= '0;
            cx_reg         <= '1;
            cy_reg         <= '1;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            code_reg       <= code_next;
            running_reg    <= running_next;
            avoid_done_reg <= avoid_done_next;
            seen_reg       <= seen_next;
            arrived_reg    <= arrived_next;
            drift_reg      <= drift_next;
            retry_reg      <= retry_next;
            fpos_reg       <= fpos_next;
            first_reg      <= first_next;
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
        end
    end

    // The result reports the state after this transaction has been applied.
    assign result.drive_code = code_next;
    assign result.mode       = mode_next;
    assign result.reached    = arrived_next;
endmodule

// ===== hdl/robot_nav_mode_controller_core.sv =====
// Top level of the navigation mode controller: input stage, state update, result register.
// Depends on rnmc_pkg, rnmc_stream_if, rnmc_cfg_regs, rnmc_nav_fsm and the defines header.
//
//  channel    | direction | payload      | transaction
//  -----------+-----------+--------------+------------------------------
//  event_ch   | in        | nav_event_t  | valid && ready at clk rise
//  result_ch  | out       | nav_result_t | valid && ready at clk rise
//  cfg port   | in        | index, data  | cfg_we at clk rise
//
// Every event yields one result: it is held in the input register, then the state
// update writes the result register.
// A new event is taken in every cycle unless a result waits and the result channel is not ready.
// While a result waits, the input register can still take one more event.
// Reset clears the valid flags and the navigation state and loads the register defaults; no clearing pass is needed.
`include "robot_nav_mode_controller_core_defines.svh"

module robot_nav_mode_controller_core #(
    parameter int IMAGE_WIDTH  = rnmc_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = rnmc_pkg::IMAGE_HEIGHT_DEF,
    parameter int RETRY_LIMIT  = rnmc_pkg::RETRY_LIMIT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rnmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rnmc_pkg::CFG_DAT_W-1:0] cfg_data,
    rnmc_stream_if.sink                    event_ch,
    rnmc_stream_if.source                  result_ch
);
    rnmc_pkg::cfg_t        cfg;
    rnmc_pkg::nav_event_t  item_reg;
    rnmc_pkg::nav_result_t result_reg;
    rnmc_pkg::nav_result_t step_result;
    logic                  in_vld_reg;
    logic                  result_vld_reg;
    logic                  advance;
    logic                  fire;

    assign advance        = !result_vld_reg || result_ch.ready;
    assign fire           = in_vld_reg && advance;
    assign event_ch.ready = !in_vld_reg || advance;

    rnmc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rnmc_nav_fsm #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .RETRY_LIMIT  (RETRY_LIMIT)
    ) u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else
        begin
            if (event_ch.ready)
                in_vld_reg <= event_ch.valid;
            if (advance)
                result_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (event_ch.ready && event_ch.valid)
            item_reg <= event_ch.data;
        if (fire)
            result_reg <= step_result;
    end

    assign result_ch.valid = result_vld_reg;
    assign result_ch.data  = result_reg;

    // An accepted event always lands in the input register.
    `RNMC_ASSERT_NEXT(a_accept_loads, clk, rst_n,
        event_ch.valid && event_ch.ready, in_vld_reg)
    // An event waiting behind a stalled result is kept, not dropped.
    `RNMC_ASSERT_NEXT(a_stage_holds, clk, rst_n,
        in_vld_reg && result_vld_reg && !result_ch.ready, in_vld_reg)
    // The reached flag is always cleared on the way back to the static mode.
    `RNMC_ASSERT_IMPLY(a_static_not_reached, clk, rst_n,
        result_vld_reg && (result_reg.mode == rnmc_pkg::MODE_STATIC), !result_reg.reached)
    // A zero stop code is refused.
    `RNMC_ASSERT_NEXT(a_zero_code_kept, clk, rst_n,
        cfg_we && (cfg_index == rnmc_pkg::CFG_CODE_STOP)
            && (cfg_data[rnmc_pkg::CODE_W-1:0] == '0),
        $stable(cfg.code_stop))
endmodule
